/* rtl/slpa_pkg.sv */
// ----------------------------------------------------------------------------
// slpa_pkg
// Shared types, constants and lookup tables for the status LED animator.
// ----------------------------------------------------------------------------
`default_nettype none

package slpa_pkg;

    localparam int STATUS_COUNT = 8;
    localparam int STATUS_LIMIT = (STATUS_COUNT < 8) ? STATUS_COUNT : 8;

    localparam logic [9:0] FORCE_WAIT_MS = 10'd100;
    localparam logic [9:0] FLASH_WAIT_MS = 10'd50;

    localparam logic [9:0] FAST_BLINK_RESET   = 10'd150;
    localparam logic [9:0] SLOW_BLINK_RESET   = 10'd500;
    localparam logic [9:0] BREATH_STEP_RESET  = 10'd50;
    localparam logic [5:0] BREATH_COUNT_RESET = 6'd20;
    localparam logic [9:0] SOLID_POLL_RESET   = 10'd200;

    localparam logic [7:0] REG_FAST_BLINK   = 8'd0;
    localparam logic [7:0] REG_SLOW_BLINK   = 8'd1;
    localparam logic [7:0] REG_BREATH_STEP  = 8'd2;
    localparam logic [7:0] REG_BREATH_COUNT = 8'd3;
    localparam logic [7:0] REG_SOLID_POLL   = 8'd4;

    localparam logic [2:0] COLOR_OFF     = 3'd0;
    localparam logic [2:0] COLOR_BLUE    = 3'd1;
    localparam logic [2:0] COLOR_RED     = 3'd2;
    localparam logic [2:0] COLOR_GREEN   = 3'd3;
    localparam logic [2:0] COLOR_CYAN    = 3'd5;
    localparam logic [2:0] COLOR_YELLOW  = 3'd6;
    localparam logic [2:0] STATUS_IDLE   = 3'd7;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_FLASH = 3'd3,
        CMD_FORCE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FAST    = 2'd0,
        KIND_SLOW    = 2'd1,
        KIND_BREATHE = 2'd2,
        KIND_SOLID   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  active_mask;
        logic        forced_dark;
        logic [15:0] flash_left;
        logic [2:0]  flash_color_held;
        logic [9:0]  wait_left;
        logic [5:0]  breath_position;
        logic        breath_rising;
        logic        blink_phase_on;
        logic [2:0]  shown_color;
    } anim_state_t;

    typedef struct packed {
        logic [9:0] fast_blink_ms;
        logic [9:0] slow_blink_ms;
        logic [9:0] breath_tick_ms;
        logic [5:0] breath_step_count;
        logic [9:0] solid_poll_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  status_index;
        logic [2:0]  flash_color;
        logic [15:0] flash_duration_ms;
        logic        force_value;
    } item_t;

    typedef struct packed {
        logic [2:0] led_color;
        logic       color_written;
        logic [2:0] winning_status;
        logic       flash_busy;
    } result_t;

    function automatic kind_t status_kind(input logic [2:0] status);
        kind_t k;
        unique case (status)
            3'd0, 3'd1: k = KIND_FAST;
            3'd2, 3'd5: k = KIND_SLOW;
            3'd3:       k = KIND_BREATHE;
            default:    k = KIND_SOLID;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] status_color(input logic [2:0] status);
        logic [2:0] c;
        unique case (status)
            3'd0, 3'd1, 3'd2: c = COLOR_RED;
            3'd3:             c = COLOR_YELLOW;
            3'd4:             c = COLOR_GREEN;
            3'd5:             c = COLOR_BLUE;
            3'd6:             c = COLOR_CYAN;
            default:          c = COLOR_OFF;
        endcase
        return c;
    endfunction

    // lowest set index wins, idle when none
    function automatic logic [2:0] winner(input logic [7:0] mask);
        logic [2:0] w;
        w = STATUS_IDLE;
        for (int i = STATUS_LIMIT - 1; i >= 0; i--) begin
            if (mask[i])
            begin
                w = 3'(i);
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/slpa_step.sv */
// ----------------------------------------------------------------------------
// slpa_step
// Next-state and result logic for one item: status mask update, flash
// countdown, wait pacing and the animation step.
// ----------------------------------------------------------------------------
`default_nettype none

module slpa_step
    import slpa_pkg::*;
(
    input  wire anim_state_t st,
    input  wire cfg_t        cfg,
    input  wire item_t       item,
    output anim_state_t      st_next,
    output result_t          res
);

    logic [2:0] win_cur;
    kind_t      kind;
    logic [2:0] color;
    logic       written;
    logic [5:0] pos_step;

    assign win_cur = winner(st.active_mask);
    assign kind    = status_kind(win_cur);
    assign color   = status_color(win_cur);

    always_comb
    begin
        st_next  = st;
        written  = 1'b0;
        pos_step = st.breath_position;
        unique case (cmd_t'(item.cmd))
            CMD_TICK:
            begin
                if (st.flash_left != 16'd0)
                begin
                    st_next.flash_left = st.flash_left - 16'd1;
                end
                if (st.wait_left > 10'd1)
                begin
                    st_next.wait_left = st.wait_left - 10'd1;
                end
                else
                begin
                    written = 1'b1;
                    if (st.forced_dark)
                    begin
                        st_next.shown_color = COLOR_OFF;
                        st_next.wait_left   = FORCE_WAIT_MS;
                    end
                    else if (st_next.flash_left != 16'd0)
                    begin
                        st_next.shown_color = st.flash_color_held;
                        st_next.wait_left   = FLASH_WAIT_MS;
                    end
                    else
                    begin
                        unique case (kind)
                            KIND_BREATHE:
                            begin
                                if (st.breath_rising)
                                begin
                                    if (st.breath_position != 6'd63)
                                    begin
                                        pos_step = st.breath_position + 6'd1;
                                    end
                                    st_next.breath_rising = !(pos_step >= cfg.breath_step_count);
                                end
                                else
                                begin
                                    if (st.breath_position != 6'd0)
                                    begin
                                        pos_step = st.breath_position - 6'd1;
                                    end
                                    st_next.breath_rising = (pos_step == 6'd0);
                                end
                                st_next.breath_position = pos_step;
                                st_next.shown_color = (pos_step > (cfg.breath_step_count >> 1))
                                                      ? color : COLOR_OFF;
                                st_next.wait_left = cfg.breath_tick_ms;
                            end
                            KIND_FAST, KIND_SLOW:
                            begin
                                st_next.shown_color    = st.blink_phase_on ? color : COLOR_OFF;
                                st_next.blink_phase_on = !st.blink_phase_on;
                                st_next.wait_left      = (kind == KIND_FAST)
                                                         ? cfg.fast_blink_ms : cfg.slow_blink_ms;
                            end
                            default:
                            begin
                                st_next.shown_color = color;
                                st_next.wait_left   = cfg.solid_poll_ms;
                            end
                        endcase
                    end
                end
            end
            CMD_SET:
            begin
                if (int'(item.status_index) < STATUS_COUNT)
                begin
                    st_next.active_mask[item.status_index] = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                if (int'(item.status_index) < STATUS_COUNT)
                begin
                    st_next.active_mask[item.status_index] = 1'b0;
                end
            end
            CMD_FLASH:
            begin
                st_next.flash_color_held = item.flash_color;
                st_next.flash_left       = item.flash_duration_ms;
            end
            CMD_FORCE:
            begin
                st_next.forced_dark = item.force_value;
                if (item.force_value)
                begin
                    st_next.shown_color = COLOR_OFF;
                    written             = 1'b1;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    assign res.led_color      = st_next.shown_color;
    assign res.color_written  = written;
    assign res.winning_status = winner(st_next.active_mask);
    assign res.flash_busy     = (st_next.flash_left != 16'd0);

endmodule

`default_nettype wire

/* rtl/status_led_priority_animator_core.sv */
// ----------------------------------------------------------------------------
// status_led_priority_animator_core
// Status LED controller with priority mask, force-off, one-shot flash and
// blink/breathe/solid animation paced by millisecond ticks.
// Results are registered: each item passes the input register, then the result
// register; throughput one item per cycle while the output is not stalled, set by
// the single state update pass. One item is held in the input register while a result waits.
// Reset (rst_n low, asynchronous) restores default config and clears state.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_priority_animator_core
    import slpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [2:0]  status_index,
    input  wire logic [2:0]  flash_color,
    input  wire logic [15:0] flash_duration_ms,
    input  wire logic        force_value,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       led_color,
    output logic             color_written,
    output logic [2:0]       winning_status,
    output logic             flash_busy
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        in_full_reg;
    logic        in_full_next;
    item_t       item_reg;
    anim_state_t state_reg;
    anim_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res_reg;
    result_t     res_next;
    logic        advance;
    logic        in_take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FAST_BLINK:   cfg_next.fast_blink_ms     = cfg_data;
                REG_SLOW_BLINK:   cfg_next.slow_blink_ms     = cfg_data;
                REG_BREATH_STEP:  cfg_next.breath_tick_ms    = cfg_data;
                REG_BREATH_COUNT: cfg_next.breath_step_count = cfg_data[5:0];
                REG_SOLID_POLL:   cfg_next.solid_poll_ms     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_blink_ms     <= FAST_BLINK_RESET;
            cfg_reg.slow_blink_ms     <= SLOW_BLINK_RESET;
            cfg_reg.breath_tick_ms    <= BREATH_STEP_RESET;
            cfg_reg.breath_step_count <= BREATH_COUNT_RESET;
            cfg_reg.solid_poll_ms     <= SOLID_POLL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake between input register and result register
    assign advance        = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_full_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign in_full_next   = in_take || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd               <= cmd;
            item_reg.status_index      <= status_index;
            item_reg.flash_color       <= flash_color;
            item_reg.flash_duration_ms <= flash_duration_ms;
            item_reg.force_value       <= force_value;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    slpa_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active_mask      <= '0;
            state_reg.forced_dark      <= 1'b0;
            state_reg.flash_left       <= '0;
            state_reg.flash_color_held <= '0;
            state_reg.wait_left        <= '0;
            state_reg.breath_position  <= '0;
            state_reg.breath_rising    <= 1'b1;
            state_reg.blink_phase_on   <= 1'b1;
            state_reg.shown_color      <= COLOR_OFF;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_color      = res_reg.led_color;
    assign color_written  = res_reg.color_written;
    assign winning_status = res_reg.winning_status;
    assign flash_busy     = res_reg.flash_busy;

    // result register always mirrors the state left by its item
    a_flash_busy_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flash_busy == (state_reg.flash_left != 16'd0)))
        else $error("flash_busy out of step with flash countdown");

    a_colour_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (led_color == state_reg.shown_color))
        else $error("led_color out of step with shown colour");

    a_forced_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && color_written && state_reg.forced_dark) |-> (led_color == COLOR_OFF))
        else $error("colour written while forced dark");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> !in_stall)
        else $error("input stalled with empty input register");

endmodule

`default_nettype wire
